/* hw/rtl/lru_page_buffer_manager_defines.svh */
// Assertion macros for the page buffer manager.
`ifndef LRU_PAGE_BUFFER_MANAGER_DEFINES_SVH
`define LRU_PAGE_BUFFER_MANAGER_DEFINES_SVH
// Assert that antecedent implies consequent in the same cycle.
`define LPB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Assert that antecedent implies consequent in the next cycle.
`define LPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* hw/rtl/lpbm_pkg.sv */
// Shared types and constants of the page buffer manager.
package lpbm_pkg;
   localparam int POOL_FRAMES_DEF = 16;
   localparam int FILE_ID_BITS_DEF = 8;
   localparam int FID_W = 8;
   localparam int OFF_W = 32;
   localparam int PIN_W = 16;
   localparam int FRAME_W = 4;
   localparam int ACT_W = 3;
   localparam logic [PIN_W-1:0] PIN_MAX = '1;

   localparam logic [1:0] REQ_GET = 2'd0;
   localparam logic [1:0] REQ_UNPIN = 2'd1;
   localparam logic [1:0] REQ_FORCE = 2'd2;
   localparam logic [1:0] REQ_FLUSH = 2'd3;

   localparam logic [ACT_W-1:0] ACT_HIT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WB = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DONE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NOFRAME = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_VSCAN, ST_VWB, ST_FILL, ST_FWALK, ST_FLAST, ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;    // capture request fields, clear scan state
      logic scan_step;   // examine frame at scan index, advance
      logic hit_apply;   // pin + touch matched frame, build hit result
      logic fill_new;    // allocate free frame, build load result
      logic victim_wb;   // build writeback result for victim
      logic victim_fill; // touch victim, install page, build load result
      logic noframe;     // build failure result
      logic unpin_apply;
      logic force_apply;
      logic miss_done;   // done with zero fields
      logic walk_step;   // examine walk index for flush
      logic walk_emit;   // build writeback for walk frame, last=0
      logic flush_last;  // mark held result last, or build empty done
      logic out_fire;    // result taken
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_done;
      logic hit;
      logic pool_full;
      logic victim_found;
      logic victim_dirty;
      logic walk_done;
      logic walk_dirty;
      logic any_emitted;
      logic out_valid;
   } sts_type;
endpackage

/* hw/rtl/lpbm_datapath.sv */
// Frame table, scan counters and result register of the page buffer manager.
module lpbm_datapath import lpbm_pkg::*; #(
   parameter int POOL_FRAMES = POOL_FRAMES_DEF,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic [1:0] in_type,
   input  logic [FID_W-1:0] in_fid,
   input  logic [OFF_W-1:0] in_off,
   input  logic in_dirty,
   output logic [ACT_W-1:0] o_action,
   output logic [FRAME_W-1:0] o_frame,
   output logic [FID_W-1:0] o_fid,
   output logic [OFF_W-1:0] o_off,
   output logic [PIN_W-1:0] o_pins,
   output logic o_last
);
   localparam int IW = $clog2(POOL_FRAMES);
   localparam int CW = $clog2(POOL_FRAMES + 1);

   logic [POOL_FRAMES-1:0] valid_ff, valid_in, mod_ff, mod_in;
   logic [PIN_W-1:0] pins_ff [POOL_FRAMES];
   logic [PIN_W-1:0] pins_in [POOL_FRAMES];
   logic [IW-1:0] rank_ff [POOL_FRAMES];
   logic [IW-1:0] rank_in [POOL_FRAMES];
   logic [FILE_ID_BITS-1:0] file_mem [POOL_FRAMES];
   logic [OFF_W-1:0] block_mem [POOL_FRAMES];
   logic [CW-1:0] used_ff, used_in;

   logic [1:0] rtype_ff;
   logic [FILE_ID_BITS-1:0] rfid_ff;
   logic [OFF_W-1:0] roff_ff;
   logic rdirty_ff;

   logic [CW-1:0] idx_ff, idx_in;
   logic hit_ff, hit_in, vfound_ff, vfound_in, emitted_ff, emitted_in;
   logic [IW-1:0] hidx_ff, hidx_in, vidx_ff, vidx_in, vrank_ff, vrank_in;
   logic [IW-1:0] ia;

   logic ov_ff, ov_in;
   logic [ACT_W-1:0] oa_ff, oa_in;
   logic [FRAME_W-1:0] of_ff, of_in;
   logic [FID_W-1:0] ofid_ff, ofid_in;
   logic [OFF_W-1:0] ooff_ff, ooff_in;
   logic [PIN_W-1:0] op_ff, op_in;
   logic ol_ff, ol_in;

   logic wr_en;
   logic [IW-1:0] wr_idx;
   logic [IW-1:0] touch_idx;
   logic touch_en;
   logic [IW-1:0] cur_rank;

   function automatic logic [IW-1:0] fillsel(cmd_type c, logic [IW-1:0] h, logic [IW-1:0] v);
      fillsel = c.hit_apply ? h : v;
   endfunction

   assign ia = idx_ff[IW-1:0];
   assign touch_idx = fillsel(cmd, hidx_ff, vidx_ff);

   assign cur_rank = rank_ff[touch_idx];
   assign touch_en = cmd.hit_apply | cmd.victim_fill;

   always_comb begin
      valid_in = valid_ff;
      mod_in = mod_ff;
      pins_in = pins_ff;
      rank_in = rank_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      hidx_in = hidx_ff;
      vfound_in = vfound_ff;
      vidx_in = vidx_ff;
      vrank_in = vrank_ff;
      emitted_in = emitted_ff;
      ov_in = ov_ff;
      oa_in = oa_ff;
      of_in = of_ff;
      ofid_in = ofid_ff;
      ooff_in = ooff_ff;
      op_in = op_ff;
      ol_in = ol_ff;
      wr_en = 1'b0;
      wr_idx = used_ff[IW-1:0];
      if (cmd.out_fire) begin
         ov_in = 1'b0;
      end
      if (cmd.load_req) begin
         idx_in = '0;
         hit_in = 1'b0;
         vfound_in = 1'b0;
         emitted_in = 1'b0;
      end
      if (cmd.scan_step) begin
         if (valid_ff[ia] && file_mem[ia] == rfid_ff && block_mem[ia] == roff_ff
             && !hit_ff) begin
            hit_in = 1'b1;
            hidx_in = ia;
         end
         if (valid_ff[ia] && pins_ff[ia] == '0 && (!vfound_ff || rank_ff[ia] > vrank_ff)) begin
            vfound_in = 1'b1;
            vidx_in = ia;
            vrank_in = rank_ff[ia];
         end
         idx_in = idx_ff + 1'b1;
      end
      if (touch_en) begin
         for (int j = 0; j < POOL_FRAMES; j++) begin
            if (valid_ff[j] && rank_ff[j] < cur_rank) begin
               rank_in[j] = rank_ff[j] + 1'b1;
            end
         end
         rank_in[touch_idx] = '0;
      end
      if (cmd.hit_apply) begin
         if (pins_ff[hidx_ff] != PIN_MAX) begin
            pins_in[hidx_ff] = pins_ff[hidx_ff] + 1'b1;
         end
         ov_in = 1'b1;
         oa_in = ACT_HIT;
         of_in = FRAME_W'(hidx_ff);
         ofid_in = FID_W'(rfid_ff);
         ooff_in = roff_ff;
         op_in = pins_in[hidx_ff];
         ol_in = 1'b1;
      end
      if (cmd.fill_new) begin
         for (int j = 0; j < POOL_FRAMES; j++) begin
            if (valid_ff[j]) begin
               rank_in[j] = rank_ff[j] + 1'b1;
            end
         end
         wr_idx = used_ff[IW-1:0];
         wr_en = 1'b1;
         rank_in[wr_idx] = '0;
         valid_in[wr_idx] = 1'b1;
         used_in = used_ff + 1'b1;
      end
      if (cmd.victim_fill) begin
         wr_idx = vidx_ff;
         wr_en = 1'b1;
      end
      if (wr_en) begin
         mod_in[wr_idx] = 1'b0;
         pins_in[wr_idx] = PIN_W'(1);
         ov_in = 1'b1;
         oa_in = ACT_LOAD;
         of_in = FRAME_W'(wr_idx);
         ofid_in = FID_W'(rfid_ff);
         ooff_in = roff_ff;
         op_in = PIN_W'(1);
         ol_in = 1'b1;
      end
      if (cmd.victim_wb) begin
         ov_in = 1'b1;
         oa_in = ACT_WB;
         of_in = FRAME_W'(vidx_ff);
         ofid_in = FID_W'(file_mem[vidx_ff]);
         ooff_in = block_mem[vidx_ff];
         op_in = '0;
         ol_in = 1'b0;
      end
      if (cmd.noframe || cmd.miss_done || (cmd.flush_last && !emitted_ff)) begin
         ov_in = 1'b1;
         oa_in = cmd.noframe ? ACT_NOFRAME : ACT_DONE;
         of_in = '0;
         ofid_in = '0;
         ooff_in = '0;
         op_in = '0;
         ol_in = 1'b1;
      end
      if (cmd.unpin_apply || cmd.force_apply) begin
         ov_in = 1'b1;
         oa_in = ACT_DONE;
         of_in = FRAME_W'(hidx_ff);
         ofid_in = FID_W'(rfid_ff);
         ooff_in = roff_ff;
         op_in = pins_ff[hidx_ff];
         ol_in = 1'b1;
         if (cmd.unpin_apply) begin
            if (pins_ff[hidx_ff] != '0) begin
               pins_in[hidx_ff] = pins_ff[hidx_ff] - 1'b1;
            end
            op_in = pins_in[hidx_ff];
            if (rdirty_ff) begin
               mod_in[hidx_ff] = 1'b1;
            end
         end else if (mod_ff[hidx_ff]) begin
            mod_in[hidx_ff] = 1'b0;
            oa_in = ACT_WB;
         end
      end
      if (cmd.walk_step) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.walk_emit) begin
         mod_in[hidx_ff] = 1'b0;
         ov_in = 1'b1;
         oa_in = ACT_WB;
         of_in = FRAME_W'(hidx_ff);
         ofid_in = FID_W'(file_mem[hidx_ff]);
         ooff_in = block_mem[hidx_ff];
         op_in = pins_ff[hidx_ff];
         ol_in = 1'b0;
         emitted_in = 1'b1;
      end
      if (cmd.flush_last && emitted_ff) begin
         ol_in = 1'b1;
      end
   end

   // Walk: rank search by index, located frame lands in hidx.
   logic walk_found;
   logic [IW-1:0] walk_idx;
   always_comb begin
      walk_found = 1'b0;
      walk_idx = '0;
      for (int j = 0; j < POOL_FRAMES; j++) begin
         if (valid_ff[j] && CW'(rank_ff[j]) == idx_ff && mod_ff[j]) begin
            walk_found = 1'b1;
            walk_idx = IW'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mod_ff <= '0;
         used_ff <= '0;
         ov_ff <= 1'b0;
         hit_ff <= 1'b0;
         vfound_ff <= 1'b0;
         emitted_ff <= 1'b0;
         idx_ff <= '0;
         for (int j = 0; j < POOL_FRAMES; j++) begin
            pins_ff[j] <= '0;
            rank_ff[j] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         mod_ff <= mod_in;
         used_ff <= used_in;
         ov_ff <= ov_in;
         hit_ff <= hit_in;
         vfound_ff <= vfound_in;
         emitted_ff <= emitted_in;
         idx_ff <= idx_in;
         pins_ff <= pins_in;
         rank_ff <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      hidx_ff <= cmd.walk_step ? walk_idx : hidx_in;
      vidx_ff <= vidx_in;
      vrank_ff <= vrank_in;
      oa_ff <= oa_in;
      of_ff <= of_in;
      ofid_ff <= ofid_in;
      ooff_ff <= ooff_in;
      op_ff <= op_in;
      ol_ff <= ol_in;
      if (cmd.load_req) begin
         rtype_ff <= in_type;
         rfid_ff <= in_fid[FILE_ID_BITS-1:0];
         roff_ff <= in_off;
         rdirty_ff <= in_dirty;
      end
      if (wr_en) begin
         file_mem[wr_idx] <= rfid_ff;
         block_mem[wr_idx] <= roff_ff;
      end
   end

   logic walk_dirty_ff;
   always_ff @(posedge clock) begin
      walk_dirty_ff <= cmd.walk_step & walk_found;
   end

   assign sts.scan_done = (idx_ff == CW'(POOL_FRAMES));
   assign sts.hit = hit_ff;
   assign sts.pool_full = (used_ff == CW'(POOL_FRAMES));
   assign sts.victim_found = vfound_ff;
   assign sts.victim_dirty = mod_ff[vidx_ff];
   assign sts.walk_done = (idx_ff == CW'(POOL_FRAMES));
   assign sts.walk_dirty = walk_dirty_ff;
   assign sts.any_emitted = emitted_ff | (rtype_ff == REQ_GET);
   assign sts.out_valid = ov_ff;

   assign o_action = oa_ff;
   assign o_frame = of_ff;
   assign o_fid = ofid_ff;
   assign o_off = ooff_ff;
   assign o_pins = op_ff;
   assign o_last = ol_ff;
endmodule

/* hw/rtl/lpbm_ctrl.sv */
// Request sequencer of the page buffer manager.
module lpbm_ctrl import lpbm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] in_type,
   input  logic req_fire,
   input  logic rsp_fire,
   output logic in_ready,
   output logic out_hold,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic [1:0] type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff <= in_type;
      end
   end

   // flush writeback stays off the bus until the walk knows if it is the last
   assign out_hold = (state_ff == ST_FWALK) || (state_ff == ST_VSCAN) ||
                     (state_ff == ST_FLAST);

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cmd = '0;
      cmd.out_fire = rsp_fire;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (req_fire) begin
               cmd.load_req = 1'b1;
               state_in = (in_type == REQ_FLUSH) ? ST_FWALK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DECIDE: begin
            ret_in = ST_IDLE;
            state_in = ST_OUT;
            if (type_ff == REQ_GET) begin
               if (sts.hit) begin
                  cmd.hit_apply = 1'b1;
               end else if (!sts.pool_full) begin
                  cmd.fill_new = 1'b1;
               end else if (!sts.victim_found) begin
                  cmd.noframe = 1'b1;
               end else if (sts.victim_dirty) begin
                  cmd.victim_wb = 1'b1;
                  ret_in = ST_FILL;
               end else begin
                  cmd.victim_fill = 1'b1;
               end
            end else if (!sts.hit) begin
               cmd.miss_done = 1'b1;
            end else if (type_ff == REQ_UNPIN) begin
               cmd.unpin_apply = 1'b1;
            end else begin
               cmd.force_apply = 1'b1;
            end
         end
         ST_FILL: begin
            if (!sts.out_valid) begin
               cmd.victim_fill = 1'b1;
               ret_in = ST_IDLE;
               state_in = ST_OUT;
            end
         end
         ST_FWALK: begin
            // one rank per cycle while no dirty frame is pending; a dirty frame found last cycle goes to emit
            if (sts.walk_dirty) begin
               state_in = ST_VWB;
            end else if (sts.walk_done) begin
               state_in = ST_FLAST;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_VWB: begin
            // release the held writeback, load the new one when it is taken
            if (!sts.out_valid || rsp_fire) begin
               cmd.walk_emit = 1'b1;
            end
            if (sts.out_valid && !rsp_fire) begin
               state_in = ST_VWB;
            end else begin
               state_in = ST_VSCAN;
            end
         end
         ST_VSCAN: begin
            if (sts.walk_done) begin
               state_in = ST_FLAST;
            end else begin
               cmd.walk_step = 1'b1;
               state_in = ST_FWALK;
            end
         end
         ST_FLAST: begin
            if (!sts.out_valid || !sts.any_emitted) begin
               if (!sts.out_valid || rsp_fire) begin
                  cmd.flush_last = 1'b1;
                  ret_in = ST_IDLE;
                  state_in = ST_OUT;
               end
            end else begin
               // last writeback still held: set its last flag in place
               cmd.flush_last = 1'b1;
               cmd.out_fire = 1'b0;
               ret_in = ST_IDLE;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

/* hw/rtl/lru_page_buffer_manager.sv */
// Top level of the LRU page buffer frame-table manager.
// Usage:
//  Requests arrive as beats on the req_ channel (get, unpin, force, flush-all).
//  Each request returns one or more beats on rsp_, the final one with
//  rsp_tlast set. One request is in service at a time; req_tready is high
//  only when the sequencer is idle.
//  Get, unpin and force scan the frame table, one frame per cycle. Flush-all
//  walks the recency ranks one per cycle while no dirty page is pending, and
//  emits one writeback beat per dirty page. A dirty eviction adds one beat.
//  A new request is accepted only once the final beat of the one in service
//  has been taken.
//  Reset (synchronous, active high) empties the table: all frames invalid,
//  unpinned and clean. No clearing pass is needed.
//  A stalled rsp_tready holds the result register; the sequencer waits for
//  the beat to be taken before producing the next one. During flush-all each
//  writeback is kept off the bus until the walk knows whether it is the last.
`include "lru_page_buffer_manager_defines.svh"
module lru_page_buffer_manager import lpbm_pkg::*; #(
   parameter int POOL_FRAMES = POOL_FRAMES_DEF,
   parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [1:0] req_tuser,   // req_type
   input  logic [47:0] req_tdata,  // file_id[7:0], page_offset[39:8], mark_dirty[40], zero
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [2:0] rsp_tuser,   // action
   output logic [63:0] rsp_tdata,  // frame[3:0], out_file_id[11:4], out_offset[43:12],
                                   // pin_level[59:44], zero
   output logic rsp_tlast
);
   cmd_type cmd;
   sts_type sts;
   logic req_fire, rsp_fire;
   logic out_hold;
   logic [ACT_W-1:0] o_action;
   logic [FRAME_W-1:0] o_frame;
   logic [FID_W-1:0] o_fid;
   logic [OFF_W-1:0] o_off;
   logic [PIN_W-1:0] o_pins;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   lpbm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_type(req_tuser), .req_fire(req_fire),
      .rsp_fire(rsp_fire), .in_ready(req_tready), .out_hold(out_hold),
      .sts(sts), .cmd(cmd)
   );

   lpbm_datapath #(.POOL_FRAMES(POOL_FRAMES), .FILE_ID_BITS(FILE_ID_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_type(req_tuser), .in_fid(req_tdata[7:0]), .in_off(req_tdata[39:8]),
      .in_dirty(req_tdata[40]), .o_action(o_action), .o_frame(o_frame),
      .o_fid(o_fid), .o_off(o_off), .o_pins(o_pins), .o_last(rsp_tlast)
   );

   assign rsp_tvalid = sts.out_valid & ~out_hold;
   assign rsp_tuser = o_action;
   assign rsp_tdata = {4'b0, o_pins, o_off, o_fid, o_frame};

   `LPB_ASSERT_IMPL(a_no_accept_busy, clock, reset, req_fire && rsp_tvalid, rsp_fire && rsp_tlast,
      "request accepted while a result is pending")
   `LPB_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result dropped under stall")
   `LPB_ASSERT_IMPL(a_action_range, clock, reset, rsp_tvalid, rsp_tuser <= ACT_NOFRAME,
      "undefined result action")
endmodule

/* dv/testbench.sv */
// Self-checking testbench for the LRU page buffer frame-table manager.
module testbench import lpbm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFR = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_LEN = 300;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  fid;
      logic [31:0] off;
      logic        dirty;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  act;
      logic [3:0]  fr;
      logic [7:0]  fid;
      logic [31:0] off;
      logic [15:0] pins;
      logic        last;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [2:0] rsp_tuser;
   logic [63:0] rsp_tdata;
   logic rsp_tlast;

   lru_page_buffer_manager u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // Shadow frame table
   logic        fv    [NFR];
   logic [7:0]  ffile [NFR];
   logic [31:0] fblk  [NFR];
   logic [15:0] fpins [NFR];
   logic        fmod  [NFR];
   int          frank [NFR];
   int          in_use;

   req_beat_type pending_reqs[$];
   rsp_beat_type expected_rsps[$];
   int errors = 0;
   bit hold_rsp = 0;     // long receiver hold-off
   bit hold_go = 0;      // starts the hold-off
   int hold_count = 0;
   bit pause_req = 0;    // sender pause until drained
   bit quiet = 0;        // stretch with no idling

   // Recently used pages, to steer random requests toward hits
   logic [7:0]  pool_fid [8];
   logic [31:0] pool_off [8];

   function automatic rsp_beat_type mk(logic [2:0] a, int f, logic [7:0] id,
                                       logic [31:0] o, logic [15:0] p, logic l);
      rsp_beat_type r;
      r.act = a; r.fr = f[3:0]; r.fid = id; r.off = o; r.pins = p; r.last = l;
      return r;
   endfunction

   function automatic int lookup(logic [7:0] id, logic [31:0] o);
      for (int i = 0; i < NFR; i++)
         if (fv[i] && ffile[i] == id && fblk[i] == o) return i;
      return -1;
   endfunction

   function automatic void make_recent(int f);
      int r;
      r = frank[f];
      for (int j = 0; j < NFR; j++)
         if (fv[j] && frank[j] < r) frank[j]++;
      frank[f] = 0;
   endfunction

   // Work out the response beats one request causes and update the shadow table.
   function automatic void predict_request(req_beat_type q);
      int f, victim, best, n;
      f = lookup(q.fid, q.off);
      case (q.kind)
         REQ_GET: begin
            if (f >= 0) begin
               make_recent(f);
               if (fpins[f] != PIN_MAX) fpins[f]++;
               expected_rsps.push_back(mk(ACT_HIT, f, q.fid, q.off, fpins[f], 1));
               return;
            end
            if (in_use < NFR) begin
               f = in_use;
               in_use++;
               for (int j = 0; j < NFR; j++) if (fv[j]) frank[j]++;
               fv[f] = 1;
               frank[f] = 0;
            end else begin
               victim = -1;
               best = 0;
               for (int j = 0; j < NFR; j++)
                  if (fv[j] && fpins[j] == 0 && (victim < 0 || frank[j] > best)) begin
                     victim = j;
                     best = frank[j];
                  end
               if (victim < 0) begin
                  expected_rsps.push_back(mk(ACT_NOFRAME, 0, 0, 0, 0, 1));
                  return;
               end
               f = victim;
               if (fmod[f])
                  expected_rsps.push_back(mk(ACT_WB, f, ffile[f], fblk[f], 0, 0));
               make_recent(f);
            end
            ffile[f] = q.fid;
            fblk[f] = q.off;
            fmod[f] = 0;
            fpins[f] = 1;
            expected_rsps.push_back(mk(ACT_LOAD, f, q.fid, q.off, 1, 1));
         end
         REQ_UNPIN, REQ_FORCE: begin
            if (f < 0) begin
               expected_rsps.push_back(mk(ACT_DONE, 0, 0, 0, 0, 1));
            end else if (q.kind == REQ_UNPIN) begin
               if (fpins[f] != 0) fpins[f]--;
               if (q.dirty) fmod[f] = 1;
               expected_rsps.push_back(mk(ACT_DONE, f, q.fid, q.off, fpins[f], 1));
            end else if (fmod[f]) begin
               fmod[f] = 0;
               expected_rsps.push_back(mk(ACT_WB, f, q.fid, q.off, fpins[f], 1));
            end else begin
               expected_rsps.push_back(mk(ACT_DONE, f, q.fid, q.off, fpins[f], 1));
            end
         end
         default: begin
            // flush-all: most recent first, last flag on the final one
            n = 0;
            for (int k = 0; k < NFR; k++)
               for (int j = 0; j < NFR; j++)
                  if (fv[j] && frank[j] == k && fmod[j]) begin
                     fmod[j] = 0;
                     expected_rsps.push_back(mk(ACT_WB, j, ffile[j], fblk[j], fpins[j], 0));
                     n++;
                  end
            if (n == 0) expected_rsps.push_back(mk(ACT_DONE, 0, 0, 0, 0, 1));
            else expected_rsps[$].last = 1;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic add(logic [1:0] k, logic [7:0] id, logic [31:0] o, logic d);
      req_beat_type q;
      q.kind = k; q.fid = id; q.off = o; q.dirty = d;
      pending_reqs.push_back(q);
   endtask

   // Driver: pops the request queue, idles at random
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request({req_tuser, req_tdata[7:0], req_tdata[39:8], req_tdata[40]});
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && !pause_req &&
                (quiet || $urandom_range(99) >= 19)) begin
               req_beat_type q;
               q = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= q.kind;
               req_tdata <= {7'b0, q.dirty, q.off, q.fid};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off, counted in cycles once started
   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_LEN) begin
         hold_rsp <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         hold_rsp <= 1'b0;
      end
   end

   // Monitor: checks each response beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, 0);
            end else begin
               rsp_beat_type e;
               e = expected_rsps.pop_front();
               if (rsp_tuser != e.act) report_mismatch("action", rsp_tuser, e.act);
               if (rsp_tdata[3:0] != e.fr) report_mismatch("frame", rsp_tdata[3:0], e.fr);
               if (rsp_tdata[11:4] != e.fid) report_mismatch("file id", rsp_tdata[11:4], e.fid);
               if (rsp_tdata[43:12] != e.off) report_mismatch("offset", rsp_tdata[43:12], e.off);
               if (rsp_tdata[59:44] != e.pins)
                  report_mismatch("pin level", rsp_tdata[59:44], e.pins);
               if (rsp_tlast != e.last) report_mismatch("last", rsp_tlast, e.last);
            end
         end
         rsp_tready <= !hold_rsp && (quiet || $urandom_range(99) >= 19);
      end
   end

   // Watchdog: cycles without any accepted beat
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("lru_page_buffer_manager: mismatch");
         $finish;
      end
   end

   initial begin
      logic [7:0] id;
      logic [31:0] o;
      int r, p;
      for (int i = 0; i < NFR; i++) begin
         fv[i] = 0; ffile[i] = 0; fblk[i] = 0; fpins[i] = 0; fmod[i] = 0; frank[i] = 0;
      end
      in_use = 0;
      for (int i = 0; i < 8; i++) begin
         pool_fid[i] = $urandom;
         pool_off[i] = $urandom;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: misses on empty table, extremes, hit, dirty unpin, force, flush
      add(REQ_FLUSH, 0, 0, 0);                    // flush with nothing dirty
      add(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1);    // unpin not resident
      add(REQ_FORCE, 0, 0, 0);                    // force not resident
      add(REQ_GET, 0, 0, 0);
      add(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 1);
      add(REQ_GET, 0, 0, 0);                      // hit
      add(REQ_UNPIN, 0, 0, 1);
      add(REQ_UNPIN, 0, 0, 0);
      add(REQ_UNPIN, 0, 0, 0);                    // pin floor at zero
      add(REQ_FORCE, 0, 0, 0);                    // dirty force
      add(REQ_FORCE, 0, 0, 0);                    // clean force
      add(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1);
      add(REQ_FLUSH, 0, 0, 0);
      // fill the pool with pinned pages, then a get finds no frame
      for (int i = 0; i < 15; i++) add(REQ_GET, 8'h10 + i, i, 0);
      add(REQ_GET, 8'hAA, 32'h5555_AAAA, 0);
      add(REQ_GET, 8'hAB, 32'h0000_0001, 0);
      // pause sender until drained
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      pause_req = 1;
      wait (expected_rsps.size() == 0 && !req_tvalid);
      repeat (40) @(posedge clock);
      pause_req = 0;

      // release some frames dirty so evictions write back, then flush
      for (int i = 0; i < 15; i++) add(REQ_UNPIN, 8'h10 + i, i, i[0]);
      add(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 0);
      add(REQ_GET, 8'h42, 32'h1234_5678, 0);      // clean eviction; the get below evicts a dirty frame
      add(REQ_GET, 8'h43, 32'h8765_4321, 0);
      // long receiver hold-off while sender keeps offering
      hold_go = 1;
      add(REQ_FLUSH, 0, 0, 0);
      for (int i = 0; i < 6; i++) add(REQ_GET, 8'h20 + i, $urandom, 0);
      wait (hold_count == HOLD_LEN);
      wait (pending_reqs.size() == 0);

      // Random part: mostly traffic on a small set of pages
      for (int n = 0; n < 55; n++) begin
         if (n == 15) quiet = 1;
         if (n == 40) quiet = 0;
         p = $urandom_range(7);
         if ($urandom_range(9) < 8) begin
            id = pool_fid[p]; o = pool_off[p];
         end else begin
            id = $urandom; o = $urandom;
            if ($urandom_range(1)) pool_fid[p] = id;
            if ($urandom_range(1)) pool_off[p] = o;
         end
         r = $urandom_range(99);
         if (r < 45) add(REQ_GET, id, o, $urandom_range(1));
         else if (r < 80) add(REQ_UNPIN, id, o, $urandom_range(1));
         else if (r < 93) add(REQ_FORCE, id, o, $urandom_range(1));
         else add(REQ_FLUSH, id, o, $urandom_range(1));
         if (pending_reqs.size() > 4) wait (pending_reqs.size() <= 4);
      end
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_tvalid && expected_rsps.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("lru_page_buffer_manager: match");
      end else begin
         $display("lru_page_buffer_manager: mismatch");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lpbm_pkg.sv
hw/rtl/lpbm_datapath.sv
hw/rtl/lpbm_ctrl.sv
hw/rtl/lru_page_buffer_manager.sv
dv/testbench.sv
